### rtl/core/ftca_pkg.sv
// Package: shared types and constants for the flavor-tag combine/accumulate block.
`default_nettype none
package ftca_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MASS_LOW   = 3'd0;
  localparam logic [2:0] REG_MASS_HIGH  = 3'd1;
  localparam logic [2:0] REG_OFFSET_OS  = 3'd2;
  localparam logic [2:0] REG_SLOPE_OS   = 3'd3;
  localparam logic [2:0] REG_PIVOT_OS   = 3'd4;
  localparam logic [2:0] REG_OFFSET_SS  = 3'd5;
  localparam logic [2:0] REG_SLOPE_SS   = 3'd6;
  localparam logic [2:0] REG_PIVOT_SS   = 3'd7;

  localparam int CFG_IDX_BITS = 4;
  localparam int CFG_DATA_BITS = 16;

  // probability fraction bits (Q0.16 on the eta ports; calibrated weights are Q1.16)
  localparam int FRACTION_BITS = 16;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_MUL,
    ST_PROD,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } back_state_t;

endpackage
`default_nettype wire

### rtl/core/ftca_if.sv
// Interfaces: valid/ready channels for events and results.
`default_nettype none
interface ftca_event_if;
  logic              valid;
  logic              ready;
  logic [15:0]       event_mass;
  logic signed [7:0] decay_tag;
  logic signed [1:0] q_os;
  logic [15:0]       eta_os;
  logic signed [1:0] q_ss;
  logic [15:0]       eta_ss;
  modport source (output valid, event_mass, decay_tag, q_os, eta_os, q_ss, eta_ss,
                  input ready);
  modport sink (input valid, event_mass, decay_tag, q_os, eta_os, q_ss, eta_ss,
                output ready);
endinterface

interface ftca_result_if #(parameter int CB = 24, parameter int SB = 40);
  logic              valid;
  logic              ready;
  logic [CB-1:0]     selected_count;
  logic signed [1:0] q_combined;
  logic [15:0]       eta_combined;
  logic [SB-1:0]     power_sum_os;
  logic [SB-1:0]     power_sum_ss;
  logic [SB-1:0]     power_sum_combined;
  logic [SB-1:0]     mistag_sum_os;
  logic [SB-1:0]     mistag_sum_ss;
  logic [SB-1:0]     mistag_sum_combined;
  logic [CB-1:0]     tagged_os;
  logic [CB-1:0]     tagged_ss;
  logic [CB-1:0]     tagged_combined;
  modport source (output valid, selected_count, q_combined, eta_combined, power_sum_os,
                  power_sum_ss, power_sum_combined, mistag_sum_os, mistag_sum_ss,
                  mistag_sum_combined, tagged_os, tagged_ss, tagged_combined,
                  input ready);
  modport sink (input valid, selected_count, q_combined, eta_combined, power_sum_os,
                power_sum_ss, power_sum_combined, mistag_sum_os, mistag_sum_ss,
                mistag_sum_combined, tagged_os, tagged_ss, tagged_combined,
                output ready);
endinterface
`default_nettype wire

### rtl/core/ftca_front.sv
// Front end: event intake, selection and two-entry queue toward the back end.
`default_nettype none
module ftca_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ftca_event_if.sink       evt,
  input  wire logic [15:0] mass_low,
  input  wire logic [15:0] mass_high,
  // queue head toward back end
  output logic             q_valid,
  input  wire logic        q_pop,
  output logic             q_sel,
  output logic [1:0]       q_qos,
  output logic [15:0]      q_eta_os,
  output logic [1:0]       q_qss,
  output logic [15:0]      q_eta_ss
);

  // entry: sel, qos, eta_os, qss, eta_ss
  logic [36:0] mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, sel;
  logic [1:0]  qo, qs;

  // an untagged or invalid decision code maps to 0
  assign qo = (evt.q_os == 2'sb10) ? 2'b00 : evt.q_os;
  assign qs = (evt.q_ss == 2'sb10) ? 2'b00 : evt.q_ss;
  assign sel = (evt.decay_tag == 8'sd1 || evt.decay_tag == -8'sd1) &&
               evt.event_mass >= mass_low && evt.event_mass <= mass_high;

  assign evt.ready = (cnt_r != 2'd2);
  assign push = evt.valid && evt.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign {q_sel, q_qos, q_eta_os, q_qss, q_eta_ss} = mem_r[rp_r];

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {sel, qo, evt.eta_os, qs, evt.eta_ss};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

### rtl/core/ftca_div.sv
// Restoring divider: quotient = floor(num * 2^16 / den), one bit per cycle.
`default_nettype none
module ftca_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [33:0] num,
  input  wire logic [33:0] den,
  output logic             busy,
  output logic [15:0]      quot
);

  logic [34:0] rem_r;
  logic [33:0] den_r;
  logic [15:0] q_r;
  logic [4:0]  cnt_r;
  logic [34:0] shifted;
  logic [35:0] trial;

  assign shifted = {rem_r[33:0], 1'b0};
  assign trial = {1'b0, shifted} - {2'b00, den_r};
  assign busy = (cnt_r != 5'd0);
  assign quot = q_r;

  // one quotient bit per cycle; num < den so quotient fits in 16 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else if (start) begin
      cnt_r <= 5'd16;
    end else if (busy) begin
      cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r <= '0;
    end else if (busy) begin
      if (!trial[35]) begin
        rem_r <= trial[34:0];
        q_r <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r <= {q_r[14:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/ftca_back.sv
// Back end: calibration, combination, division and saturating accumulators.
`default_nettype none
module ftca_back #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire logic        q_sel,
  input  wire logic [1:0]  q_qos,
  input  wire logic [15:0] q_eta_os,
  input  wire logic [1:0]  q_qss,
  input  wire logic [15:0] q_eta_ss,
  input  wire logic [15:0] offset_os,
  input  wire logic [15:0] slope_os,
  input  wire logic [15:0] pivot_os,
  input  wire logic [15:0] offset_ss,
  input  wire logic [15:0] slope_ss,
  input  wire logic [15:0] pivot_ss,
  ftca_result_if.source    res
);

  localparam int SB = COUNT_BITS + ftca_pkg::FRACTION_BITS;
  localparam logic [16:0] ONE = 17'd65536;
  localparam logic [16:0] HALF = 17'd32768;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [SB-1:0] SMAX = '1;

  ftca_pkg::back_state_t st_r, st_nxt;

  logic        sel_r;
  logic [1:0]  qo_r, qs_r, qc_r;
  logic [15:0] eo_r, es_r;
  logic [16:0] wo_r, ws_r, wc_r;
  logic [33:0] pb_r, pbb_r;
  logic        div_start, div_busy;
  logic [15:0] div_q;
  logic        out_valid_r;

  logic [COUNT_BITS-1:0] evt_r, tco_r, tcs_r, tcc_r;
  logic [SB-1:0] pwo_r, pws_r, pwc_r, mso_r, mss_r, msc_r;

  // calibration w = clamp(round((off*2^14 + slope*(eta-piv)) / 2^14))
  function automatic logic [16:0] calib(input logic [15:0] eta, input logic [15:0] off,
                                        input logic [15:0] slope, input logic [15:0] piv);
    logic signed [16:0] diff;
    logic signed [34:0] acc;
    logic signed [20:0] w;
    diff = $signed({1'b0, eta}) - $signed({1'b0, piv});
    acc = $signed({5'd0, off, 14'd0}) + 35'($signed(slope) * diff) + 35'sd8192;
    w = acc[34:14];
    if (w < 0) calib = 17'd0;
    else if (w > 21'sd65536) calib = ONE;
    else calib = w[16:0];
  endfunction

  function automatic logic [16:0] fb(input logic [1:0] q, input logic [16:0] w);
    case (q)
      2'b01: fb = ONE - w;
      2'b11: fb = w;
      default: fb = HALF;
    endcase
  endfunction

  function automatic logic [16:0] fbb(input logic [1:0] q, input logic [16:0] w);
    case (q)
      2'b01: fbb = w;
      2'b11: fbb = ONE - w;
      default: fbb = HALF;
    endcase
  endfunction

  function automatic logic [SB-1:0] pw(input logic [16:0] w);
    logic [17:0] d;
    logic [35:0] sq;
    d = ({1'b0, w} > {2'b00, HALF[15:0]}) ? ({w, 1'b0} - {1'b0, ONE}) :
                                           ({1'b0, ONE} - {w, 1'b0});
    sq = d * d;
    pw = SB'(sq[35:16]);
  endfunction

  function automatic logic [SB-1:0] sadd(input logic [SB-1:0] a, input logic [SB-1:0] b);
    logic [SB:0] s;
    s = {1'b0, a} + {1'b0, b};
    sadd = s[SB] ? SMAX : s[SB-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] cinc(input logic [COUNT_BITS-1:0] a);
    cinc = (a == CMAX) ? a : a + 1'b1;
  endfunction

  ftca_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(pb_r < pbb_r ? pb_r : pbb_r), .den(pb_r + pbb_r),
    .busy(div_busy), .quot(div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ftca_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    div_start = 1'b0;
    case (st_r)
      ftca_pkg::ST_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop = 1'b1;
          st_nxt = ftca_pkg::ST_CAL;
        end
      end
      ftca_pkg::ST_CAL: st_nxt = sel_r ? ftca_pkg::ST_MUL : ftca_pkg::ST_OUT;
      ftca_pkg::ST_MUL: st_nxt = ftca_pkg::ST_PROD;
      ftca_pkg::ST_PROD: begin
        if (pb_r != pbb_r) begin
          div_start = 1'b1;
          st_nxt = ftca_pkg::ST_DIV;
        end else begin
          st_nxt = ftca_pkg::ST_ACC;
        end
      end
      ftca_pkg::ST_DIV: begin
        if (!div_busy && !div_start) st_nxt = ftca_pkg::ST_ACC;
      end
      ftca_pkg::ST_ACC: st_nxt = ftca_pkg::ST_OUT;
      ftca_pkg::ST_OUT: st_nxt = ftca_pkg::ST_IDLE;
      default: st_nxt = ftca_pkg::ST_IDLE;
    endcase
  end

  // datapath; weights land at the end of ST_CAL, products at the end of ST_MUL
  always_ff @(posedge clk) begin
    case (st_r)
      ftca_pkg::ST_IDLE: begin
        if (q_pop) begin
          sel_r <= q_sel;
          qo_r <= q_qos;
          qs_r <= q_qss;
          eo_r <= q_eta_os;
          es_r <= q_eta_ss;
        end
      end
      ftca_pkg::ST_CAL: begin
        wo_r <= calib(eo_r, offset_os, slope_os, pivot_os);
        ws_r <= calib(es_r, offset_ss, slope_ss, pivot_ss);
        qc_r <= 2'b00;
        wc_r <= HALF;
      end
      ftca_pkg::ST_DIV: begin
        if (!div_busy && !div_start) begin
          qc_r <= (pb_r > pbb_r) ? 2'b01 : 2'b11;
          wc_r <= {1'b0, div_q};
        end
      end
      default: begin
      end
    endcase
  end

  // probability products, registered unconditionally from the current weights
  always_ff @(posedge clk) begin
    pb_r <= fb(qo_r, wo_r) * fb(qs_r, ws_r);
    pbb_r <= fbb(qo_r, wo_r) * fbb(qs_r, ws_r);
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_r <= '0; tco_r <= '0; tcs_r <= '0; tcc_r <= '0;
      pwo_r <= '0; pws_r <= '0; pwc_r <= '0;
      mso_r <= '0; mss_r <= '0; msc_r <= '0;
    end else if (st_r == ftca_pkg::ST_ACC) begin
      evt_r <= cinc(evt_r);
      if (qo_r == 2'b01 || qo_r == 2'b11) begin
        pwo_r <= sadd(pwo_r, pw(wo_r));
        mso_r <= sadd(mso_r, SB'(wo_r));
        tco_r <= cinc(tco_r);
      end
      if (qs_r == 2'b01 || qs_r == 2'b11) begin
        pws_r <= sadd(pws_r, pw(ws_r));
        mss_r <= sadd(mss_r, SB'(ws_r));
        tcs_r <= cinc(tcs_r);
      end
      if (qc_r != 2'b00) begin
        pwc_r <= sadd(pwc_r, pw(wc_r));
        msc_r <= sadd(msc_r, SB'(wc_r));
        tcc_r <= cinc(tcc_r);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ftca_pkg::ST_OUT) begin
      out_valid_r <= 1'b1;
    end else if (res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ftca_pkg::ST_OUT) begin
      res.q_combined <= sel_r ? qc_r : 2'b00;
      res.eta_combined <= sel_r ? wc_r[15:0] : HALF[15:0];
    end
  end

  assign res.valid = out_valid_r;
  assign res.selected_count = evt_r;
  assign res.power_sum_os = pwo_r;
  assign res.power_sum_ss = pws_r;
  assign res.power_sum_combined = pwc_r;
  assign res.mistag_sum_os = mso_r;
  assign res.mistag_sum_ss = mss_r;
  assign res.mistag_sum_combined = msc_r;
  assign res.tagged_os = tco_r;
  assign res.tagged_ss = tcs_r;
  assign res.tagged_combined = tcc_r;

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ftca_pkg::ST_IDLE) else $error("pop outside idle");
  a_acc_sel: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ftca_pkg::ST_ACC |-> sel_r) else $error("accumulate on rejected event");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ftca_pkg::ST_OUT |-> !out_valid_r) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

### rtl/core/flavour_tag_combine_accumulate.sv
// Top level: flavor-tag combination and tagging-power accumulator.
// A rejected event passes from ST_CAL straight to ST_OUT; equal probabilities skip the divider.
// The back end takes one event at a time; the 16-step serial divider is its slowest path.
// A two-entry queue takes events while the back end works.
// Synchronous active-low reset clears all sums, counts and control; config regs reload defaults.
`default_nettype none
module flavour_tag_combine_accumulate #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  ftca_event_if.sink                                 in_evt,
  ftca_result_if.source                              out_res,
  input  wire logic                                  cfg_we,
  input  wire logic [ftca_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [ftca_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic [15:0] ml_r, mh_r, oo_r, so_r, po_r, os_r, ss_r, ps_r;
  logic        q_valid, q_pop, q_sel;
  logic [1:0]  q_qos, q_qss;
  logic [15:0] q_eta_os, q_eta_ss;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_r <= 16'd5230; mh_r <= 16'd5320;
      oo_r <= 16'd26214; so_r <= 16'd16384; po_r <= 16'd24248;
      os_r <= 16'd28836; ss_r <= 16'd16384; ps_r <= 16'd28836;
    end else if (cfg_we && !cfg_index[3]) begin
      case (cfg_index[2:0])
        ftca_pkg::REG_MASS_LOW:  ml_r <= cfg_data;
        ftca_pkg::REG_MASS_HIGH: mh_r <= cfg_data;
        ftca_pkg::REG_OFFSET_OS: oo_r <= cfg_data;
        ftca_pkg::REG_SLOPE_OS:  so_r <= cfg_data;
        ftca_pkg::REG_PIVOT_OS:  po_r <= cfg_data;
        ftca_pkg::REG_OFFSET_SS: os_r <= cfg_data;
        ftca_pkg::REG_SLOPE_SS:  ss_r <= cfg_data;
        ftca_pkg::REG_PIVOT_SS:  ps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ftca_front u_front (
    .clk(clk), .rst_n(rst_n), .evt(in_evt), .mass_low(ml_r), .mass_high(mh_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_sel(q_sel), .q_qos(q_qos),
    .q_eta_os(q_eta_os), .q_qss(q_qss), .q_eta_ss(q_eta_ss)
  );

  ftca_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_sel(q_sel),
    .q_qos(q_qos), .q_eta_os(q_eta_os), .q_qss(q_qss), .q_eta_ss(q_eta_ss),
    .offset_os(oo_r), .slope_os(so_r), .pivot_os(po_r),
    .offset_ss(os_r), .slope_ss(ss_r), .pivot_ss(ps_r), .res(out_res)
  );

endmodule
`default_nettype wire

### tb/ftca_tb_if.sv
// Testbench-side note: channel interfaces come from the RTL; this file holds the event and tally record types.
`default_nettype none
package ftca_tb_pkg;
  typedef struct packed {
    logic [15:0]       mass;
    logic signed [7:0] tag;
    logic signed [1:0] qo;
    logic [15:0]       etao;
    logic signed [1:0] qs;
    logic [15:0]       etas;
  } event_t;

  typedef struct packed {
    logic [23:0]       sel;
    logic signed [1:0] qc;
    logic [15:0]       etac;
    logic [39:0]       pwo, pws, pwc, mso, mss, msc;
    logic [23:0]       tco, tcs, tcc;
  } tally_t;
endpackage
`default_nettype wire

### tb/tb_flavour_tag_combine_accumulate.sv
// Testbench: random and directed events against a tagging-power predictor.
`default_nettype none
module tb_flavour_tag_combine_accumulate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 65536;
  localparam longint CNT_MAX = (64'd1 << 24) - 1;
  localparam longint SUM_MAX = (64'd1 << 40) - 1;
  localparam longint LIMIT = 2000000;
  localparam int IDXW = ftca_pkg::CFG_IDX_BITS;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [ftca_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [ftca_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  ftca_event_if in_evt();
  ftca_result_if out_res();

  flavour_tag_combine_accumulate DUT (
    .clk(clk), .rst_n(rst_n), .in_evt(in_evt), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] win_lo, win_hi, off_o, piv_o, off_s, piv_s;
  logic signed [15:0] slp_o, slp_s;
  ftca_tb_pkg::tally_t acc;
  ftca_tb_pkg::tally_t expected_q[$];

  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off = 0;
  int errors = 0;
  longint cycles = 0;

  initial forever #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** flavour_tag_combine_accumulate: FAILED **");
      $finish;
    end
  end

  function automatic longint sat(longint a, longint b, longint mx);
    return (a + b > mx) ? mx : a + b;
  endfunction

  function automatic longint calib(logic [15:0] eta, logic [15:0] off,
                                   logic signed [15:0] slp, logic [15:0] piv);
    longint a, w;
    a = longint'(off) * 16384 + longint'(slp) * (longint'(eta) - longint'(piv)) + 8192;
    w = a >>> 14;
    if (w < 0) w = 0;
    if (w > ONE) w = ONE;
    return w;
  endfunction

  function automatic int decide(logic signed [1:0] q);
    return (q == 1 || q == -1) ? int'(q) : 0;
  endfunction

  function automatic void tally_one(int q, longint w, inout logic [39:0] pw,
                                    inout logic [39:0] ms, inout logic [23:0] tc);
    longint d;
    if (q == 0) return;
    d = ONE - 2 * w;
    if (d < 0) d = -d;
    pw = 40'(sat(pw, (d * d) >> 16, SUM_MAX));
    ms = 40'(sat(ms, w, SUM_MAX));
    tc = 24'(sat(tc, 1, CNT_MAX));
  endfunction

  // advance the accumulator model by one event
  function automatic ftca_tb_pkg::tally_t predict_tally(ftca_tb_pkg::event_t e);
    int qo, qs, qc;
    longint wo, ws, bo, bbo, bs, bbs, pb, pbb, lo, ec;
    qc = 0;
    ec = ONE / 2;
    if ((e.tag == 1 || e.tag == -1) && e.mass >= win_lo && e.mass <= win_hi) begin
      qo = decide(e.qo);
      qs = decide(e.qs);
      wo = calib(e.etao, off_o, slp_o, piv_o);
      ws = calib(e.etas, off_s, slp_s, piv_s);
      bo = (qo == 1) ? ONE - wo : (qo == -1) ? wo : ONE / 2;
      bbo = (qo == 1) ? wo : (qo == -1) ? ONE - wo : ONE / 2;
      bs = (qs == 1) ? ONE - ws : (qs == -1) ? ws : ONE / 2;
      bbs = (qs == 1) ? ws : (qs == -1) ? ONE - ws : ONE / 2;
      pb = bo * bs;
      pbb = bbo * bbs;
      if (pb != pbb) begin
        lo = (pb < pbb) ? pb : pbb;
        qc = (pb > pbb) ? 1 : -1;
        ec = (lo << 16) / (pb + pbb);
      end
      acc.sel = 24'(sat(acc.sel, 1, CNT_MAX));
      tally_one(qo, wo, acc.pwo, acc.mso, acc.tco);
      tally_one(qs, ws, acc.pws, acc.mss, acc.tcs);
      tally_one(qc, ec, acc.pwc, acc.msc, acc.tcc);
    end
    acc.qc = 2'(qc);
    acc.etac = 16'(ec);
    return acc;
  endfunction

  // configuration write, block idle
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= IDXW'(idx);
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      ftca_pkg::REG_MASS_LOW: win_lo = val;
      ftca_pkg::REG_MASS_HIGH: win_hi = val;
      ftca_pkg::REG_OFFSET_OS: off_o = val;
      ftca_pkg::REG_SLOPE_OS: slp_o = val;
      ftca_pkg::REG_PIVOT_OS: piv_o = val;
      ftca_pkg::REG_OFFSET_SS: off_s = val;
      ftca_pkg::REG_SLOPE_SS: slp_s = val;
      ftca_pkg::REG_PIVOT_SS: piv_s = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // one event transfer
  task automatic send_event(ftca_tb_pkg::event_t e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_evt.valid <= 1;
    in_evt.event_mass <= e.mass;
    in_evt.decay_tag <= e.tag;
    in_evt.q_os <= e.qo;
    in_evt.eta_os <= e.etao;
    in_evt.q_ss <= e.qs;
    in_evt.eta_ss <= e.etas;
    @(posedge clk);
    while (!in_evt.ready) @(posedge clk);
    expected_q.push_back(predict_tally(e));
    @(negedge clk);
    in_evt.valid <= 0;
  endtask

  function automatic ftca_tb_pkg::event_t rand_event(bit in_window);
    ftca_tb_pkg::event_t e;
    e.mass = in_window ? 16'($urandom_range(win_hi, win_lo)) : 16'($urandom);
    e.tag = in_window ? (($urandom_range(1)) ? 8'sd1 : -8'sd1) : 8'($urandom);
    e.qo = 2'($urandom);
    e.qs = 2'($urandom);
    e.etao = ($urandom_range(9) == 0) ? 16'($urandom_range(1) ? 16'hFFFF : 0) : 16'($urandom);
    e.etas = 16'($urandom);
    return e;
  endfunction

  // receiver ready
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_res.ready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    ftca_tb_pkg::tally_t got, exp_r;
    if (rst_n && out_res.valid && out_res.ready) begin
      got = '{out_res.selected_count, out_res.q_combined, out_res.eta_combined,
              out_res.power_sum_os, out_res.power_sum_ss, out_res.power_sum_combined,
              out_res.mistag_sum_os, out_res.mistag_sum_ss, out_res.mistag_sum_combined,
              out_res.tagged_os, out_res.tagged_ss, out_res.tagged_combined};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) $display("mismatch\n  exp %p\n  got %p", exp_r, got);
        end
      end
    end
  end

  task automatic test_directed();
    ftca_tb_pkg::event_t e;
    logic signed [7:0] tags[5] = '{1, -1, 0, 127, -128};
    foreach (tags[i]) begin
      e = '{16'd5275, tags[i], 2'sd1, 16'd0, -2'sd1, 16'hFFFF};
      send_event(e);
    end
    for (int i = 0; i < 16; i++) begin
      e.mass = 16'((i == 0) ? win_lo : (i == 1) ? win_hi : (i == 2) ? win_lo - 1 :
                   (i == 3) ? win_hi + 1 : 5250 + i);
      e.tag = tags[i % 5];
      e.qo = 2'(i);
      e.qs = 2'(i >> 2);
      e.etao = (i & 1) ? 16'hFFFF : 16'h0000;
      e.etas = (i & 2) ? 16'hFFFF : 16'h8000;
      send_event(e);
    end
    // equal probabilities, both untagged
    e = '{16'd5275, 8'sd1, 2'sd0, 16'd100, 2'sd0, 16'd200};
    send_event(e);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_event(rand_event($urandom_range(9) < 8));
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 87; recv_stall_pct = 0;  test_random(120);
    send_idle_pct = 0;  recv_stall_pct = 87; test_random(120);
    send_idle_pct = 10; recv_stall_pct = 10; test_random(120);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(120);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    test_random(20);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(ftca_pkg::REG_SLOPE_OS, 16'h8000);
    write_reg(ftca_pkg::REG_SLOPE_SS, 16'h7FFF);
    write_reg(ftca_pkg::REG_OFFSET_OS, 16'hFFFF);
    write_reg(ftca_pkg::REG_PIVOT_OS, 16'h0000);
    write_reg(ftca_pkg::REG_OFFSET_SS, 16'h0000);
    write_reg(ftca_pkg::REG_PIVOT_SS, 16'hFFFF);
    write_reg(ftca_pkg::REG_MASS_LOW, 16'h0000);
    write_reg(ftca_pkg::REG_MASS_HIGH, 16'hFFFF);
    test_random(80);
    drain();
    // inverted window rejects everything
    write_reg(ftca_pkg::REG_MASS_LOW, 16'd6000);
    write_reg(ftca_pkg::REG_MASS_HIGH, 16'd5000);
    test_random(20);
    drain();
    // random calibration
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 8; r++) write_reg(3'(r), 16'($urandom));
      if (win_lo > win_hi) write_reg(ftca_pkg::REG_MASS_HIGH, 16'hFFFF);
      test_random(40);
      drain();
    end
  endtask

  initial begin
    in_evt.valid = 0;
    in_evt.event_mass = 0; in_evt.decay_tag = 0; in_evt.q_os = 0;
    in_evt.eta_os = 0; in_evt.q_ss = 0; in_evt.eta_ss = 0;
    out_res.ready = 0;
    win_lo = 5230; win_hi = 5320; off_o = 26214; slp_o = 16384; piv_o = 24248;
    off_s = 28836; slp_s = 16384; piv_s = 28836;
    acc = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_idle_phases();
    test_backpressure();
    test_config_extremes();
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** flavour_tag_combine_accumulate: PASSED **");
    end else begin
      $display("** flavour_tag_combine_accumulate: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

### flavour_tag_combine_accumulate.f
rtl/core/ftca_pkg.sv
rtl/core/ftca_if.sv
rtl/core/ftca_front.sv
rtl/core/ftca_div.sv
rtl/core/ftca_back.sv
rtl/core/flavour_tag_combine_accumulate.sv
tb/ftca_tb_if.sv
tb/tb_flavour_tag_combine_accumulate.sv
